### design/tslr_pkg.sv
// ----------------------------------------------------------------------------
// tslr_pkg
// Shared types, sizes and character codes for the timestamped sample log ring.
// ----------------------------------------------------------------------------
package tslr_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned DIV_W    = 7;
  localparam int unsigned TXT_LEN  = 14;
  localparam int unsigned RADIX    = 10;
  localparam int unsigned RECIP    = 205;
  localparam int unsigned RECIP_SH = 11;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    KIND_STORE  = 3'd0,
    KIND_COUNT  = 3'd1,
    KIND_NEWEST = 3'd2,
    KIND_DUMP   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_CLEAR  = 2'd0,
    REPLY_COUNT  = 2'd1,
    REPLY_RECORD = 2'd2,
    REPLY_NONE   = 2'd3
  } reply_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_READ,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } record_t;

  function automatic logic [7:0] digit_char(input logic [3:0] v);
    return {4'h0, v} + CH_ZERO;
  endfunction

endpackage

### design/timestamped_sample_log_ring_top.sv
// ----------------------------------------------------------------------------
// timestamped_sample_log_ring_top
// Ring log of timestamped light readings with ASCII count, newest and dump
// replies, built around one shared divide-by-ten unit.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o | kind, hour, minute, second, lum digits
//  out     | out_valid_o / out_ready_i | reply_kind, text_low/high, length, last
//
//  Store: written in the input transfer. Clear and empty replies: registered
//  from the input transfer, then the output transfer. Count: one pass through
//  the divider, then the output transfer. Each record: memory read, hour,
//  minute, second through the shared divide-by-ten unit, then its output
//  transfer. Input is held off while an item is in progress.
//  Reset empties the log; the record memory itself is not cleared.
// ----------------------------------------------------------------------------
module timestamped_sample_log_ring_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [3:0]  lum_hundreds_i,
  input  logic [3:0]  lum_tens_i,
  input  logic [3:0]  lum_units_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  reply_kind_o,
  output logic [63:0] text_low_o,
  output logic [47:0] text_high_o,
  output logic [3:0]  text_length_o,
  output logic        last_o
);
  import tslr_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  state_e               state_q, state_d;
  logic [PTR_W-1:0]     wp_q, wp_d, rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d, remain_q, remain_d;
  record_t              mem_q [DEPTH];
  record_t              rd_data_q;
  record_t              wr_rec;
  logic                 mem_we;
  logic [7:0]           hr_hi_q, hr_hi_d, hr_lo_q, hr_lo_d;
  logic [7:0]           mi_hi_q, mi_hi_d, mi_lo_q, mi_lo_d;
  logic                 out_valid_q, out_valid_d;
  reply_e               reply_q, reply_d;
  logic [63:0]          text_low_q, text_low_d;
  logic [47:0]          text_high_q, text_high_d;
  logic [3:0]           len_q, len_d;
  logic                 last_q, last_d;

  kind_e                kind_in;
  logic                 in_fire, out_fire;
  logic [SUM_W-1:0]     oldest_w;
  logic [PTR_W-1:0]     oldest_idx, newest_idx, wp_inc, rd_inc;

  logic [DIV_W-1:0]     div_x, div_q, div_r;
  logic [DIV_W+7:0]     div_prod;
  logic [7:0]           q_char, r_char;

  logic [7:0]           txt [TXT_LEN];
  logic [3:0]           txt_len;
  logic [63:0]          txt_low;
  logic [47:0]          txt_high;

  assign kind_in    = kind_e'(kind_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign wr_rec = '{hour: hour_i, minute: minute_i, second: second_i,
                    hundreds: lum_hundreds_i, tens: lum_tens_i, units: lum_units_i};

  assign wp_inc     = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rd_inc     = (rd_idx_q == PTR_W'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
  assign newest_idx = (wp_q == '0) ? PTR_W'(DEPTH - 1) : wp_q - 1'b1;
  assign oldest_w   = SUM_W'(wp_q) + SUM_W'(DEPTH) - SUM_W'(cnt_q);
  assign oldest_idx = (oldest_w >= SUM_W'(DEPTH)) ? PTR_W'(oldest_w - SUM_W'(DEPTH))
                                                  : PTR_W'(oldest_w);

  // shared divide-by-ten unit
  always_comb begin
    unique case (state_q)
      ST_COUNT: div_x = DIV_W'(cnt_q);
      ST_HOUR:  div_x = DIV_W'(rd_data_q.hour);
      ST_MIN:   div_x = DIV_W'(rd_data_q.minute);
      ST_SEC:   div_x = DIV_W'(rd_data_q.second);
      default:  div_x = '0;
    endcase
  end

  assign div_prod = (DIV_W + 8)'(div_x) * (DIV_W + 8)'(RECIP);
  assign div_q    = DIV_W'(div_prod >> RECIP_SH);
  assign div_r    = div_x - ((div_q << 3) + (div_q << 1));
  assign q_char   = digit_char(div_q[3:0]);
  assign r_char   = digit_char(div_r[3:0]);

  // text assembly
  always_comb begin
    txt     = '{default: '0};
    txt_len = '0;
    if (state_q == ST_COUNT) begin
      if (cnt_q >= CNT_W'(RADIX)) begin
        txt[0]  = q_char;
        txt[1]  = r_char;
        txt_len = 4'd2;
      end else begin
        txt[0]  = digit_char(4'(cnt_q));
        txt_len = 4'd1;
      end
    end else if (state_q == ST_SEC) begin
      txt[0] = hr_hi_q;
      txt[1] = hr_lo_q;
      txt[2] = CH_COLON;
      txt[3] = mi_hi_q;
      txt[4] = mi_lo_q;
      txt[5] = CH_COLON;
      txt[6] = q_char;
      txt[7] = r_char;
      txt[8] = CH_DASH;
      if (rd_data_q.hundreds != '0) begin
        txt[9]  = digit_char(rd_data_q.hundreds);
        txt[10] = digit_char(rd_data_q.tens);
        txt[11] = CH_DOT;
        txt[12] = digit_char(rd_data_q.units);
        txt[13] = CH_PCT;
        txt_len = 4'd14;
      end else begin
        txt[9]  = digit_char(rd_data_q.tens);
        txt[10] = CH_DOT;
        txt[11] = digit_char(rd_data_q.units);
        txt[12] = CH_PCT;
        txt_len = 4'd13;
      end
    end
    txt_low  = {txt[7], txt[6], txt[5], txt[4], txt[3], txt[2], txt[1], txt[0]};
    txt_high = {txt[13], txt[12], txt[11], txt[10], txt[9], txt[8]};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind_in)
            KIND_COUNT:  state_d = ST_COUNT;
            KIND_NEWEST,
            KIND_DUMP:   state_d = (cnt_q == '0) ? ST_OUT : ST_READ;
            KIND_CLEAR:  state_d = ST_OUT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_COUNT: state_d = ST_OUT;
      ST_READ:  state_d = ST_HOUR;
      ST_HOUR:  state_d = ST_MIN;
      ST_MIN:   state_d = ST_SEC;
      ST_SEC:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_d = (remain_q > CNT_W'(1)) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    remain_d    = remain_q;
    mem_we      = 1'b0;
    hr_hi_d     = hr_hi_q;
    hr_lo_d     = hr_lo_q;
    mi_hi_d     = mi_hi_q;
    mi_lo_d     = mi_lo_q;
    out_valid_d = out_valid_q;
    reply_d     = reply_q;
    text_low_d  = text_low_q;
    text_high_d = text_high_q;
    len_d       = len_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind_in)
            KIND_STORE: begin
              mem_we = 1'b1;
              wp_d   = wp_inc;
              if (cnt_q < CNT_W'(DEPTH)) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            KIND_COUNT: remain_d = '0;
            KIND_NEWEST,
            KIND_DUMP: begin
              if (cnt_q == '0) begin
                remain_d    = '0;
                out_valid_d = 1'b1;
                reply_d     = REPLY_NONE;
                text_low_d  = '0;
                text_high_d = '0;
                len_d       = '0;
                last_d      = 1'b1;
              end else if (kind_in == KIND_NEWEST) begin
                rd_idx_d = newest_idx;
                remain_d = CNT_W'(1);
              end else begin
                rd_idx_d = oldest_idx;
                remain_d = cnt_q;
              end
            end
            KIND_CLEAR: begin
              wp_d        = '0;
              cnt_d       = '0;
              remain_d    = '0;
              out_valid_d = 1'b1;
              reply_d     = REPLY_CLEAR;
              text_low_d  = '0;
              text_high_d = '0;
              len_d       = '0;
              last_d      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        out_valid_d = 1'b1;
        reply_d     = REPLY_COUNT;
        text_low_d  = txt_low;
        text_high_d = txt_high;
        len_d       = txt_len;
        last_d      = 1'b1;
      end
      ST_READ: ;
      ST_HOUR: begin
        hr_hi_d = q_char;
        hr_lo_d = r_char;
      end
      ST_MIN: begin
        mi_hi_d = q_char;
        mi_lo_d = r_char;
      end
      ST_SEC: begin
        out_valid_d = 1'b1;
        reply_d     = REPLY_RECORD;
        text_low_d  = txt_low;
        text_high_d = txt_high;
        len_d       = txt_len;
        last_d      = (remain_q == CNT_W'(1));
      end
      ST_OUT: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (remain_q > CNT_W'(1)) begin
            remain_d = remain_q - 1'b1;
            rd_idx_d = rd_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    hr_hi_q     <= hr_hi_d;
    hr_lo_q     <= hr_lo_d;
    mi_hi_q     <= mi_hi_d;
    mi_lo_q     <= mi_lo_d;
    reply_q     <= reply_d;
    text_low_q  <= text_low_d;
    text_high_q <= text_high_d;
    len_q       <= len_d;
    last_q      <= last_d;
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= wr_rec;
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign reply_kind_o  = reply_q;
  assign text_low_o    = text_low_q;
  assign text_high_o   = text_high_q;
  assign text_length_o = len_q;
  assign last_o        = last_q;

`ifndef NO_ASSERTIONS
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("record count above depth");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (reply_kind_o != REPLY_RECORD)) |-> last_o)
    else $error("single reply without last flag");

  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == KIND_STORE) && (cnt_q < CNT_W'(DEPTH)))
      |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("store transfer did not advance the count");
`endif

endmodule
